FILE: design/acal_pkg.sv
// acal_pkg: types, constants and helper functions for the accelerometer offset calibration
// block. It depends on nothing else and is imported by every module of the block.
package acal_pkg;

   localparam int RawWidth     = 16;
   localparam int SumWidth     = 16;
   localparam int CountWidth   = 6;
   localparam int ByteWidth    = 8;
   localparam int GravWidth    = 10;
   localparam int ShiftWidth   = 4;
   localparam int CsrDataWidth = 10;
   localparam int QuotWidth    = 16;
   localparam int StepWidth    = 5;

   // register indexes of the configuration port
   localparam logic CSR_GRAVITY_COUNTS = 1'b0;
   localparam logic CSR_JUSTIFY_SHIFT  = 1'b1;

   localparam logic [GravWidth-1:0]  GRAVITY_RESET = 10'd256;
   localparam logic [ShiftWidth-1:0] SHIFT_RESET   = 4'd6;

   // one incoming sample
   typedef struct packed {
      logic signed [RawWidth-1:0] raw_x;
      logic signed [RawWidth-1:0] raw_y;
      logic signed [RawWidth-1:0] raw_z;
      logic                       last;
   } req_payload_type;

   // one calibration result
   typedef struct packed {
      logic [ByteWidth-1:0]  offset_x;
      logic [ByteWidth-1:0]  offset_y;
      logic [ByteWidth-1:0]  offset_z;
      logic [CountWidth-1:0] used_samples;
      logic                  dropped;
   } rsp_payload_type;

   // accumulator contents seen by the sequencer
   typedef struct packed {
      logic signed [SumWidth-1:0] sum_x;
      logic signed [SumWidth-1:0] sum_y;
      logic signed [SumWidth-1:0] sum_z;
      logic [CountWidth-1:0]      count;
      logic                       overflow;
   } acc_status_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // negate, divide by four toward zero and keep the low byte
   function automatic logic [ByteWidth-1:0] offset_byte(input logic signed [17:0] avg);
      logic signed [18:0] neg;
      logic signed [18:0] quo;
      neg = 19'sd0 - {avg[17], avg};
      quo = neg[18] ? ((neg + 19'sd3) >>> 2) : (neg >>> 2);
      return quo[ByteWidth-1:0];
   endfunction

endpackage

FILE: design/acal_accum.sv
// acal_accum: per-axis wrapping sums of the justified samples, sample count and drop flag.
// Depends on acal_pkg.
module acal_accum #(
   parameter int MAX_SAMPLES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            take,
   input  acal_pkg::req_payload_type       sample,
   input  logic [acal_pkg::ShiftWidth-1:0] justify_shift,
   input  logic                            clear,
   output acal_pkg::acc_status_type        status
);
   import acal_pkg::*;

   logic signed [SumWidth-1:0] sum_x_ff, sum_y_ff, sum_z_ff;
   logic signed [SumWidth-1:0] sum_x_in, sum_y_in, sum_z_in;
   logic [CountWidth-1:0]      count_ff, count_in;
   logic                       overflow_ff, overflow_in;
   logic                       room;

   assign room = count_ff < CountWidth'(MAX_SAMPLES);

   // clear empties the run; else add the arithmetically shifted words, or flag the drop once the run is full
   always_comb begin
      sum_x_in    = sum_x_ff;
      sum_y_in    = sum_y_ff;
      sum_z_in    = sum_z_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (clear) begin
         sum_x_in    = '0;
         sum_y_in    = '0;
         sum_z_in    = '0;
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (take) begin
         if (room) begin
            sum_x_in = sum_x_ff + (sample.raw_x >>> justify_shift);
            sum_y_in = sum_y_ff + (sample.raw_y >>> justify_shift);
            sum_z_in = sum_z_ff + (sample.raw_z >>> justify_shift);
            count_in = count_ff + CountWidth'(1);
         end else begin
            overflow_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff    <= '0;
         sum_y_ff    <= '0;
         sum_z_ff    <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         sum_x_ff    <= sum_x_in;
         sum_y_ff    <= sum_y_in;
         sum_z_ff    <= sum_z_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   assign status.sum_x    = sum_x_ff;
   assign status.sum_y    = sum_y_ff;
   assign status.sum_z    = sum_z_ff;
   assign status.count    = count_ff;
   assign status.overflow = overflow_ff;

endmodule

FILE: design/acal_div.sv
// acal_div: shared restoring divider, signed 16-bit sum by unsigned count, one quotient bit
// per cycle, truncating toward zero. Depends on acal_pkg.
module acal_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [acal_pkg::SumWidth-1:0] dividend,
   input  logic [acal_pkg::CountWidth-1:0]   divisor,
   output acal_pkg::div_status_type          status,
   output logic signed [acal_pkg::QuotWidth:0] quotient
);
   import acal_pkg::*;

   logic [CountWidth-1:0] rem_ff, rem_in;
   logic [QuotWidth-1:0]  quo_ff, quo_in;
   logic [CountWidth-1:0] dvs_ff, dvs_in;
   logic                  neg_ff, neg_in;
   logic                  busy_ff, busy_in;
   logic [StepWidth-1:0]  step_ff, step_in;
   logic [CountWidth:0]   trial;
   logic                  fits;
   logic                  done;

   assign done  = busy_ff && (step_ff == '0);
   assign trial = {rem_ff, quo_ff[QuotWidth-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   // load magnitude on start, then shift in one quotient bit per cycle
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[SumWidth-1] ? QuotWidth'(~dividend + 1'b1)
                                        : QuotWidth'(dividend);
         dvs_in  = divisor;
         neg_in  = dividend[SumWidth-1];
         busy_in = 1'b1;
         step_in = StepWidth'(QuotWidth);
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = fits ? CountWidth'(trial - {1'b0, dvs_ff}) : trial[CountWidth-1:0];
         quo_in  = {quo_ff[QuotWidth-2:0], fits};
         step_in = step_ff - StepWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign quotient    = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign status.busy = busy_ff;
   assign status.done = done;

endmodule

FILE: design/accel_offset_calibration.sv
// accel_offset_calibration: samples are taken one per cycle while idle and added to the sums.
// The last sample of a run starts three 16-step divisions on one shared divider, x, y then z; the
// result is loaded into the output register and offered once the z division is done, or
// later if the previous result is still waiting. Samples are refused from the last one until
// the result is loaded, then taken again while it waits. Depends on acal_pkg and submodules.
// Synchronous reset restores gravity_counts 256, justify_shift 6 and empty sums.
module accel_offset_calibration #(
   parameter int MAX_SAMPLES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  acal_pkg::req_payload_type         req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output acal_pkg::rsp_payload_type         rsp_data,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [acal_pkg::CsrDataWidth-1:0] csr_wdata
);
   import acal_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LOAD = 4'b0010,
      ST_WAIT = 4'b0100,
      ST_HOLD = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   axis_type                   axis_ff, axis_in;
   logic [GravWidth-1:0]       gravity_ff;
   logic [ShiftWidth-1:0]      shift_ff;
   logic [ByteWidth-1:0]       byte_x_ff, byte_y_ff, byte_z_ff;
   logic [ByteWidth-1:0]       byte_x_in, byte_y_in, byte_z_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_payload_type            rsp_data_ff, rsp_data_in;
   acc_status_type             acc;
   div_status_type             div_stat;
   logic signed [QuotWidth:0]  quotient;
   logic signed [SumWidth-1:0] dividend;
   logic signed [17:0]         avg;
   logic signed [17:0]         adj;
   logic [ByteWidth-1:0]       obyte;
   logic                       take;
   logic                       div_start;
   logic                       load_rsp;

   assign req_ready = (state_ff == ST_IDLE);
   assign take      = req_valid && req_ready;
   assign div_start = (state_ff == ST_LOAD);
   assign load_rsp  = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_ready);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= GRAVITY_RESET;
         shift_ff   <= SHIFT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRAVITY_COUNTS: gravity_ff <= csr_wdata[GravWidth-1:0];
            CSR_JUSTIFY_SHIFT:  shift_ff   <= csr_wdata[ShiftWidth-1:0];
            default:            gravity_ff <= gravity_ff;
         endcase
      end
   end

   acal_accum #(
      .MAX_SAMPLES(MAX_SAMPLES)
   ) u_accum (
      .clock         (clock),
      .reset         (reset),
      .take          (take),
      .sample        (req_data),
      .justify_shift (shift_ff),
      .clear         (load_rsp),
      .status        (acc)
   );

   // pick the sum of the axis under division
   always_comb begin
      unique case (axis_ff)
         AXIS_X:  dividend = acc.sum_x;
         AXIS_Y:  dividend = acc.sum_y;
         AXIS_Z:  dividend = acc.sum_z;
         default: dividend = acc.sum_x;
      endcase
   end

   acal_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (acc.count),
      .status   (div_stat),
      .quotient (quotient)
   );

   // gravity removal on z: subtract gravity_counts from a positive average, add it to a zero or negative one
   assign avg = {quotient[QuotWidth], quotient};
   always_comb begin
      if (axis_ff == AXIS_Z) begin
         if (!avg[17] && (avg != '0)) begin
            adj = avg - $signed({8'd0, gravity_ff});
         end else begin
            adj = avg + $signed({8'd0, gravity_ff});
         end
      end else begin
         adj = avg;
      end
   end
   assign obyte = offset_byte(adj);

   // sequencer over the three axes
   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      byte_x_in = byte_x_ff;
      byte_y_in = byte_y_ff;
      byte_z_in = byte_z_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && req_data.last) begin
               state_in = ST_LOAD;
               axis_in  = AXIS_X;
            end
         end
         ST_LOAD: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_stat.done) begin
               unique case (axis_ff)
                  AXIS_X: begin
                     byte_x_in = obyte;
                     axis_in   = AXIS_Y;
                     state_in  = ST_LOAD;
                  end
                  AXIS_Y: begin
                     byte_y_in = obyte;
                     axis_in   = AXIS_Z;
                     state_in  = ST_LOAD;
                  end
                  default: begin
                     byte_z_in = obyte;
                     state_in  = ST_HOLD;
                  end
               endcase
            end
         end
         ST_HOLD: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.offset_x      = byte_x_ff;
         rsp_data_in.offset_y      = byte_y_ff;
         rsp_data_in.offset_z      = byte_z_ff;
         rsp_data_in.used_samples  = acc.count;
         rsp_data_in.dropped       = acc.overflow;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_x_ff   <= byte_x_in;
      byte_y_ff   <= byte_y_in;
      byte_z_ff   <= byte_z_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // run length never passes the maximum
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      acc.count <= CountWidth'(MAX_SAMPLES))
      else $error("sample count beyond maximum");

   // a fresh result always averages at least one sample
   a_result_count: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (rsp_data.used_samples != '0))
      else $error("result with zero samples");

   // handing over a result empties the accumulator
   a_clear_after: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (acc.count == '0) && !acc.overflow)
      else $error("accumulator not cleared after result");

   // the divider only runs while a run is being finished
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_stat.busy)
      else $error("divider busy while idle");

endmodule
